// File: design/hfls_pkg.sv
// ---------------------------------------------------------------------------
// hfls_pkg
// Shared types, constants and the ln(1+e^-d) correction function for the
// log-domain forward block.
// ---------------------------------------------------------------------------
package hfls_pkg;

  localparam int MaxStates      = 16;
  localparam int StateW         = $clog2(MaxStates);
  localparam int CorrTableDepth = 256;
  localparam int CorrW          = $clog2(CorrTableDepth);
  localparam int TransDepth     = MaxStates * MaxStates;
  localparam int TransAw        = $clog2(TransDepth);
  localparam int NumW           = 5;
  localparam int ValW           = 32;
  localparam int LikeW          = 48;
  localparam int AccW           = 40;

  localparam logic [0:0] REQ_LOAD = 1'b0;
  localparam logic [0:0] REQ_EMIT = 1'b1;

  localparam logic [0:0] CFG_NUM_STATES = 1'b0;
  localparam logic [0:0] CFG_EMIT_ALPHA = 1'b1;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [LikeW-1:0] like_t;

  localparam like_t LikeMax = {1'b0, {(LikeW-1){1'b1}}};
  localparam like_t LikeMin = {1'b1, {(LikeW-1){1'b0}}};

  // shift-subtract quotient, elaboration-time table build only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f, f in Q30, 0 <= f <= 1.0 (elaboration-time table build only)
  function automatic longint unsigned exp_neg_q30(input longint unsigned f);
    longint unsigned t;
    longint unsigned pos;
    longint unsigned neg;
    t = 64'd1 << 30;
    pos = 64'd1 << 30;
    neg = 0;
    for (int k = 1; k <= 20; k++) begin
      t = udiv64((t * f) >> 30, longint'(k));
      if ((k & 1) != 0) neg += t;
      else pos += t;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [ValW-1:0] ln1p_q16(input longint unsigned y);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned term;
    longint unsigned sum;
    z = udiv64(y << 30, (64'd2 << 30) + y);
    z2 = (z * z) >> 30;
    term = z;
    sum = z;
    for (int k = 3; k <= 31; k += 2) begin
      term = (term * z2) >> 30;
      sum += udiv64(term, longint'(k));
    end
    return ValW'((2 * sum + (64'd1 << 13)) >> 14);
  endfunction

  function automatic logic [ValW-1:0] corr_entry(input int i);
    longint unsigned e1;
    longint unsigned d;
    longint unsigned y;
    e1 = exp_neg_q30(64'd1 << 30);
    d = (longint'(i) << 20) >> CorrW;
    y = exp_neg_q30((d & 64'hFFFF) << 14);
    for (longint unsigned j = 0; j < (d >> 16); j++) y = (y * e1) >> 30;
    return ln1p_q16(y);
  endfunction

  typedef logic [ValW-1:0] corr_rom_t [CorrTableDepth];

  function automatic corr_rom_t build_corr();
    corr_rom_t r;
    for (int i = 0; i < CorrTableDepth; i++) r[i] = corr_entry(i);
    return r;
  endfunction

  localparam corr_rom_t CorrRom = build_corr();

  function automatic val_t sat32(input acc_t v);
    if (v > acc_t'(32'sh7FFFFFFF)) return val_t'(32'sh7FFFFFFF);
    if (v < -acc_t'(64'sh80000000)) return val_t'(32'sh80000000);
    return val_t'(v);
  endfunction

endpackage

// File: design/hfls_ram.sv
// ---------------------------------------------------------------------------
// hfls_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module hfls_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/hfls_lse.sv
// ---------------------------------------------------------------------------
// hfls_lse
// Pairwise log-sum-exp step: max(a,b) + corr(|a-b|), table lookup.
// ---------------------------------------------------------------------------
module hfls_lse (
  input  hfls_pkg::acc_t a,
  input  hfls_pkg::acc_t b,
  output hfls_pkg::acc_t y
);
  import hfls_pkg::*;

  acc_t m;
  acc_t d;
  logic [CorrW-1:0] idx;

  always_comb begin
    m = (a > b) ? a : b;
    d = (a > b) ? a - b : b - a;
    idx = d[20-1 -: CorrW];
    if (d >= acc_t'(64'd1 << 20)) y = m;
    else y = m + acc_t'(val_t'(CorrRom[idx]));
  end
endmodule

// File: design/hmm_forward_log_scaled.sv
// ---------------------------------------------------------------------------
// hmm_forward_log_scaled
// Log-domain HMM forward step with per-step normalization, Q16.16.
// ---------------------------------------------------------------------------
// channel  dir  handshake          fields
// in       in   in_valid/in_ready  req_type row_state col_state log_value ...
// out      out  out_valid/out_ready state_index alpha_value step_scale ...
// cfg      in   cfg_we             cfg_index cfg_data
// a transition load is written straight to memory; a mid-step emission does
// one transition/alpha memory read per source state (none at a sequence start).
// the last state of a step adds a normalize pass and an alpha rewrite, then results;
// with every alpha returned, each result waits until the one before it is taken.
// one item is worked at a time; results stall on out_ready.
// reset clears control and the log-likelihood; memories need no clearing.
module hmm_forward_log_scaled (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [3:0]                    row_state,
  input  logic [3:0]                    col_state,
  input  logic signed [31:0]            log_value,
  input  logic signed [31:0]            init_log,
  input  logic                          seq_start,
  input  logic                          batch_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    state_index,
  output logic signed [31:0]            alpha_value,
  output logic signed [31:0]            step_scale,
  output logic signed [47:0]            log_like,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [hfls_pkg::NumW-1:0]     cfg_data
);
  import hfls_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_WR   = 7'b0000100,
    S_NRM  = 7'b0001000,
    S_SCL  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_RES  = 7'b1000000
  } state_t;

  state_t st;
  logic [NumW-1:0] num_states;
  logic emit_alpha;
  logic [StateW-1:0] n_m1;

  logic [StateW-1:0] row;
  val_t val;
  logic [StateW:0] cnt;   // issue counter, runs to n
  logic rd_v;             // read data valid this cycle
  logic first;
  acc_t acc;
  acc_t acc_next;
  acc_t term;
  val_t scale;
  like_t like_sum;
  logic in_acc;
  val_t scale_new;
  logic signed [LikeW+1:0] like_wide;
  like_t like_new;

  // memories
  logic tr_we;
  logic [TransAw-1:0] tr_waddr, tr_raddr;
  val_t tr_rdata;
  logic pa_we;
  logic [StateW-1:0] pa_waddr, pa_raddr;
  val_t pa_wdata, pa_rdata;
  logic na_we;
  logic [StateW-1:0] na_waddr, na_raddr;
  val_t na_wdata, na_rdata;
  logic [StateW-1:0] rd_idx;

  hfls_ram #(.Width(ValW), .Depth(TransDepth)) u_tr (
    .clk, .we(tr_we), .waddr(tr_waddr), .wdata(log_value),
    .raddr(tr_raddr), .rdata(tr_rdata));
  hfls_ram #(.Width(ValW), .Depth(MaxStates)) u_pa (
    .clk, .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
    .raddr(pa_raddr), .rdata(pa_rdata));
  hfls_ram #(.Width(ValW), .Depth(MaxStates)) u_na (
    .clk, .we(na_we), .waddr(na_waddr), .wdata(na_wdata),
    .raddr(na_raddr), .rdata(na_rdata));

  hfls_lse u_lse (.a(acc), .b(term), .y(acc_next));

  always_comb begin
    if (num_states == '0) n_m1 = '0;
    else if (num_states > NumW'(MaxStates)) n_m1 = StateW'(MaxStates - 1);
    else n_m1 = StateW'(num_states - 1'b1);
  end

  assign in_ready = (st == S_IDLE);
  assign in_acc = in_valid && in_ready;

  // idle issues entry 0 of the incoming row; result readout runs one entry ahead
  always_comb begin
    unique case (st)
      S_IDLE:  rd_idx = '0;
      S_RES:   rd_idx = StateW'(cnt + 1'b1);
      default: rd_idx = cnt[StateW-1:0];
    endcase
  end

  always_comb begin
    tr_we = in_acc && (req_type == REQ_LOAD);
    tr_waddr = {row_state, col_state};
    tr_raddr = {((st == S_IDLE) ? row_state : row), rd_idx};
    pa_raddr = rd_idx;
    na_raddr = rd_idx;
    term = '0;
    case (st)
      S_SUM: term = acc_t'(tr_rdata) + acc_t'(pa_rdata);
      S_NRM: term = acc_t'(na_rdata);
      default: term = '0;
    endcase
  end

  assign na_we = (st == S_WR);
  assign na_waddr = row;
  assign na_wdata = sat32(acc + acc_t'(val));
  assign pa_we = (st == S_SCL) && rd_v;
  assign pa_waddr = StateW'(cnt - 1'b1);
  assign pa_wdata = sat32(acc_t'(na_rdata) + acc_t'(scale));

  always_comb begin
    scale_new = sat32(-acc);
    like_wide = (LikeW+2)'(like_sum) - (LikeW+2)'(scale_new);
    if (like_wide > (LikeW+2)'(LikeMax)) like_new = LikeMax;
    else if (like_wide < (LikeW+2)'(LikeMin)) like_new = LikeMin;
    else like_new = like_t'(like_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      num_states <= NumW'(16);
      emit_alpha <= 1'b0;
      like_sum <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
      rd_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_STATES: num_states <= cfg_data;
          CFG_EMIT_ALPHA: emit_alpha <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st)
        S_IDLE: begin
          if (in_acc && req_type == REQ_EMIT) begin
            if (batch_start) like_sum <= '0;
            if ({1'b0, row_state} <= {1'b0, n_m1}) begin
              row <= row_state;
              val <= log_value;
              first <= 1'b1;
              if (seq_start) begin
                acc <= acc_t'(init_log);
                st <= S_WR;
              end else begin
                cnt <= (StateW+1)'(1);
                rd_v <= 1'b1;
                st <= S_SUM;
              end
            end
          end
        end
        S_SUM: begin
          first <= 1'b0;
          acc <= first ? term : acc_next;
          if (cnt > {1'b0, n_m1}) begin
            rd_v <= 1'b0;
            st <= S_WR;
          end else cnt <= cnt + 1'b1;
        end
        S_WR: begin
          if (row == n_m1) begin
            cnt <= '0;
            rd_v <= 1'b0;
            first <= 1'b1;
            st <= S_NRM;
          end else st <= S_IDLE;
        end
        S_NRM: begin
          if (rd_v) begin
            first <= 1'b0;
            acc <= first ? term : acc_next;
          end
          if (cnt <= {1'b0, n_m1}) begin
            cnt <= cnt + 1'b1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              scale <= scale_new;
              like_sum <= like_new;
              cnt <= '0;
              st <= S_SCL;
            end
          end
        end
        S_SCL: begin
          // rewrite normalized alphas, one per cycle
          if (cnt <= {1'b0, n_m1}) begin
            cnt <= cnt + 1'b1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              cnt <= '0;
              st <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            if (emit_alpha) begin
              rd_v <= 1'b1;
              st <= S_RES;
            end else begin
              state_index <= '0;
              alpha_value <= '0;
              step_scale <= scale;
              log_like <= like_sum;
              last <= 1'b1;
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
            st <= S_IDLE;
          end
        end
        S_RES: begin
          // pa_rdata holds entry cnt
          if (!out_valid || out_ready) begin
            if (rd_v) begin
              state_index <= cnt[StateW-1:0];
              alpha_value <= pa_rdata;
              step_scale <= scale;
              log_like <= like_sum;
              last <= (cnt[StateW-1:0] == n_m1);
              out_valid <= 1'b1;
              rd_v <= 1'b0;
            end else if (out_valid && last) begin
              out_valid <= 1'b0;
              cnt <= '0;
              st <= S_IDLE;
            end else begin
              out_valid <= 1'b0;
              cnt <= cnt + 1'b1;
              rd_v <= 1'b1;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    na_we |-> row <= n_m1)
    else $error("alpha write out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alpha_value))
    else $error("result dropped under stall");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(st))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type == REQ_EMIT && !seq_start && row_state <= n_m1 |=> !in_ready)
    else $error("emission did not start work");
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives transition loads and per-state emission items into the log-domain
// forward block over several state counts and output modes, predicts the
// normalized alphas, step scale and log-likelihood, and checks every result.
// ---------------------------------------------------------------------------
module testbench;
  import hfls_pkg::*;

  typedef struct {
    logic              req;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [31:0] lval;
    logic signed [31:0] ilog;
    logic              ss;
    logic              bs;
  } fwd_item_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] alpha;
    logic signed [31:0] scale;
    logic signed [47:0] like;
    logic               lst;
  } fwd_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic req_type = 0;
  logic [3:0] row_state = 0;
  logic [3:0] col_state = 0;
  logic signed [31:0] log_value = 0;
  logic signed [31:0] init_log = 0;
  logic seq_start = 0;
  logic batch_start = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0] state_index;
  logic signed [31:0] alpha_value;
  logic signed [31:0] step_scale;
  logic signed [47:0] log_like;
  logic last;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [NumW-1:0] cfg_data = 0;

  hmm_forward_log_scaled u_dut (.*);

  always #4 clk = ~clk;

  // predictor state
  longint corr_lut [256];
  longint trans_tab [16][16];
  longint prev_lp [16];
  longint raw_lp [16];
  longint like_acc;
  int unsigned cur_nstates = 16;
  bit cur_emit = 0;

  fwd_item_t item_q [$];
  fwd_res_t  result_q [$];
  int errs = 0;
  int n_results = 0;
  bit send_gaps = 1;
  bit recv_stalls = 1;

  // generator-side tracking of written entries
  bit g_trans [16][16];
  bit g_prev [16];
  bit g_new [16];

  function automatic longint unsigned exp_series(longint unsigned f);
    longint unsigned t, pos, neg;
    t = 64'd1 << 30;
    pos = t;
    neg = 0;
    for (int k = 1; k <= 20; k++) begin
      t = ((t * f) >> 30) / k;
      if (k & 1) neg += t;
      else pos += t;
    end
    return pos > neg ? pos - neg : 0;
  endfunction

  function automatic longint log1p_fix(longint unsigned y);
    longint unsigned z, z2, term, acc;
    z = (y << 30) / ((64'd2 << 30) + y);
    z2 = (z * z) >> 30;
    term = z;
    acc = z;
    for (int k = 3; k <= 31; k += 2) begin
      term = (term * z2) >> 30;
      acc += term / k;
    end
    return longint'((2 * acc + (64'd1 << 13)) >> 14);
  endfunction

  function automatic longint sat_val(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint pair_lse(longint a, longint b);
    longint m;
    longint unsigned d;
    m = a > b ? a : b;
    d = a > b ? longint'(a - b) : longint'(b - a);
    if (d >= (64'd1 << 20)) return m;
    return m + corr_lut[(d * 256) >> 20];
  endfunction

  function automatic int unsigned clamp_n(int unsigned v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  task automatic predict_forward(fwd_item_t it);
    int unsigned n;
    longint acc, scale;
    fwd_res_t r;
    n = clamp_n(cur_nstates);
    if (it.req == REQ_LOAD) begin
      trans_tab[it.row][it.col] = it.lval;
      return;
    end
    if (it.bs) like_acc = 0;
    if (it.row >= n) return;
    if (it.ss) acc = it.ilog;
    else begin
      acc = trans_tab[it.row][0] + prev_lp[0];
      for (int s = 1; s < n; s++) acc = pair_lse(acc, trans_tab[it.row][s] + prev_lp[s]);
    end
    raw_lp[it.row] = sat_val(acc + it.lval);
    if (it.row != n - 1) return;
    acc = raw_lp[0];
    for (int s = 1; s < n; s++) acc = pair_lse(acc, raw_lp[s]);
    scale = sat_val(-acc);
    for (int s = 0; s < n; s++) prev_lp[s] = sat_val(raw_lp[s] + scale);
    like_acc = like_acc - scale;
    if (like_acc > 64'sh7FFFFFFFFFFF) like_acc = 64'sh7FFFFFFFFFFF;
    if (like_acc < -64'sh800000000000) like_acc = -64'sh800000000000;
    for (int s = 0; s < n; s++) begin
      if (cur_emit || s == n - 1) begin
        r.idx = cur_emit ? s[3:0] : 4'd0;
        r.alpha = cur_emit ? prev_lp[s][31:0] : 32'sd0;
        r.scale = scale[31:0];
        r.like = like_acc[47:0];
        r.lst = (s == n - 1);
        result_q.push_back(r);
      end
    end
  endtask

  // mostly probability-like values, some anywhere in the range
  function automatic logic [31:0] draw_log();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 32'h0004_0000);
      default: return -$urandom_range(0, 32'h0014_0000);
    endcase
  endfunction

  // keeps emissions away from never-written table and alpha entries
  task automatic push_emit(int unsigned n, logic [3:0] row, bit ss, bit bs,
                           logic [31:0] lv, logic [31:0] il);
    fwd_item_t it;
    bit ok;
    if (row < n) begin
      ok = 1;
      for (int s = 0; s < n; s++) if (!g_trans[row][s] || !g_prev[s]) ok = 0;
      if (!ok) ss = 1;
      // a step end needs every lower raw alpha written first
      if (row == n - 1) begin
        for (int s = 0; s < n - 1; s++) if (!g_new[s]) row = 0;
      end
      g_new[row] = 1;
      if (row == n - 1) for (int s = 0; s < n; s++) g_prev[s] = 1;
    end
    it.req = REQ_EMIT;
    it.row = row;
    it.col = 4'($urandom);
    it.lval = lv;
    it.ilog = il;
    it.ss = ss;
    it.bs = bs;
    item_q.push_back(it);
  endtask

  task automatic push_load(logic [3:0] row, logic [3:0] col, logic [31:0] lv);
    fwd_item_t it;
    it.req = REQ_LOAD;
    it.row = row;
    it.col = col;
    it.lval = lv;
    it.ilog = $urandom;
    it.ss = 1'($urandom);
    it.bs = 1'($urandom);
    g_trans[row][col] = 1;
    item_q.push_back(it);
  endtask

  task automatic push_step(int unsigned n, bit ss, bit bs);
    for (int s = 0; s < n; s++)
      push_emit(n, 4'(s), ss, bs && s == 0, draw_log(), draw_log());
  endtask

  task automatic drain();
    wait (item_q.size() == 0 && !in_valid && result_q.size() == 0);
    // the block can still be busy with an item that gives no result
    repeat (60) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [NumW-1:0] data);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_NUM_STATES) cur_nstates = data;
    else cur_emit = data[0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // sender
  int gap = 0;
  always @(posedge clk) begin
    fwd_item_t it;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_forward('{req_type, row_state, col_state, log_value, init_log,
                          seq_start, batch_start});
        gap = send_gaps ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        gap--;
        in_valid <= 0;
      end else if (item_q.size() > 0) begin
        it = item_q.pop_front();
        req_type <= it.req;
        row_state <= it.row;
        col_state <= it.col;
        log_value <= it.lval;
        init_log <= it.ilog;
        seq_start <= it.ss;
        batch_start <= it.bs;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver
  int hold = 0;
  always @(posedge clk) begin
    fwd_res_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("unexpected result idx=%0d alpha=%0d", state_index, alpha_value);
          errs++;
        end else begin
          e = result_q.pop_front();
          if (state_index !== e.idx) begin
            $error("state_index exp %0d got %0d", e.idx, state_index); errs++;
          end
          if (alpha_value !== e.alpha) begin
            $error("alpha_value exp %0d got %0d", e.alpha, alpha_value); errs++;
          end
          if (step_scale !== e.scale) begin
            $error("step_scale exp %0d got %0d", e.scale, step_scale); errs++;
          end
          if (log_like !== e.like) begin
            $error("log_like exp %0d got %0d", e.like, log_like); errs++;
          end
          if (last !== e.lst) begin
            $error("last exp %0d got %0d", e.lst, last); errs++;
          end
        end
        // one long hold-off so the block backs up into its input
        if (n_results == 40) hold = 400;
        else hold = recv_stalls ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  int unsigned ph_n [8] = '{16, 1, 0, 31, 5, 2, 17, 9};
  bit ph_emit [8] = '{1, 0, 1, 0, 1, 1, 0, 1};

  initial begin
    int unsigned n, cnt;
    for (int i = 0; i < 256; i++) begin
      longint unsigned d, y, e1;
      e1 = exp_series(64'd1 << 30);
      d = (longint'(i) << 20) / 256;
      y = exp_series((d & 64'hFFFF) << 14);
      for (longint unsigned j = 0; j < (d >> 16); j++) y = (y * e1) >> 30;
      corr_lut[i] = log1p_fix(y);
    end
    like_acc = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // full transition table first, so later steps never read unwritten entries
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) push_load(4'(r), 4'(c), draw_log());
    // directed: extreme emissions, init values and both step kinds
    push_emit(16, 4'd0, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_emit(16, 4'd1, 1, 0, 32'h8000_0000, 32'h8000_0000);
    for (int s = 2; s < 16; s++) push_emit(16, 4'(s), 1, 0, -(s << 16), 0);
    push_step(16, 0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      send_gaps = (p % 3 != 2);
      recv_stalls = (p % 3 != 1);
      cfg_write(CFG_NUM_STATES, NumW'(ph_n[p]));
      cfg_write(CFG_EMIT_ALPHA, NumW'(ph_emit[p]));
      n = clamp_n(ph_n[p]);
      if (p == 1) begin
        // out-of-range rows are dropped, batch clear still applies
        push_emit(n, 4'd15, 0, 1, $urandom, $urandom);
        push_emit(n, 4'(n - 1), 0, 0, 32'h7FFF_FFFF, 0);
      end
      cnt = 0;
      while (cnt < 18) begin
        case ($urandom_range(0, 9))
          0: begin
            push_load(4'($urandom), 4'($urandom), draw_log());
            cnt++;
          end
          1: begin
            push_emit(n, 4'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                      draw_log(), draw_log());
            cnt++;
          end
          default: begin
            push_step(n, $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
            cnt += n;
          end
        endcase
      end
      drain();
    end

    if (errs == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
